[hw/rtl/mtfd_pkg.sv]
// Shared types and constants for the move-to-front unique deque.
`timescale 1ns / 1ps

package mtfd_pkg;

    // Default sizing of the store.
    localparam int CAPACITY_DEF = 16;
    localparam int ID_WIDTH_DEF = 16;

    // Fixed widths of the stream fields.
    localparam int ID_FIELD_W   = 16;
    localparam int CNT_FIELD_W  = 5;
    localparam int IN_TDATA_W   = 16;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 56;
    localparam int OUT_TUSER_W  = 2;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] KIND_ADD_NEWEST  = 2'd0;
    localparam logic [1:0] KIND_ADD_OLDEST  = 2'd1;
    localparam logic [1:0] KIND_TAKE_NEWEST = 2'd2;
    localparam logic [1:0] KIND_TAKE_OLDEST = 2'd3;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic       en;
        logic [1:0] kind;
    } t_cell_ctrl;

endpackage

[hw/rtl/mtfd_cell.sv]
// One slot of the deque: holds an identifier and shifts it to a neighbor on command.
`timescale 1ns / 1ps

module mtfd_cell #(
    parameter int ID_WIDTH = mtfd_pkg::ID_WIDTH_DEF,
    parameter int CNT_W    = 5,
    parameter int IDX      = 0
) (
    input  logic                    i_clk,
    input  mtfd_pkg::t_cell_ctrl    i_ctrl,
    input  logic [ID_WIDTH-1:0]     i_id,
    input  logic [CNT_W-1:0]        i_count,
    input  logic [CNT_W-1:0]        i_target,
    input  logic [ID_WIDTH-1:0]     i_left,
    input  logic [ID_WIDTH-1:0]     i_right,
    input  logic                    i_seen,
    output logic                    o_seen,
    output logic                    o_match,
    output logic [ID_WIDTH-1:0]     o_slot,
    output logic [ID_WIDTH-1:0]     o_tail
);

    logic [ID_WIDTH-1:0] r_slot;
    logic [ID_WIDTH-1:0] n_slot;
    logic                w_valid;

    // The slot holds a live entry when its position lies below the count.
    assign w_valid = CNT_W'(IDX) < i_count;
    assign o_match = w_valid && (r_slot == i_id);
    assign o_seen  = i_seen | o_match;
    assign o_slot  = r_slot;

    // Only the last live slot drives the oldest-entry reduction.
    assign o_tail = (i_count == CNT_W'(IDX + 1)) ? r_slot : '0;

    // Next slot value for the current operation.
    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.en) begin
            unique case (i_ctrl.kind)
                mtfd_pkg::KIND_ADD_NEWEST: begin
                    // Shift toward the back up to the old copy (or everything on a miss).
                    if (IDX == 0) begin
                        n_slot = i_id;
                    end else if (!i_seen) begin
                        n_slot = i_left;
                    end
                end
                mtfd_pkg::KIND_ADD_OLDEST: begin
                    // Close the gap behind the old copy, then place the new one at the tail.
                    if (i_target == CNT_W'(IDX)) begin
                        n_slot = i_id;
                    end else if (i_seen || o_match) begin
                        n_slot = i_right;
                    end
                end
                mtfd_pkg::KIND_TAKE_NEWEST: begin
                    n_slot = i_right;
                end
                mtfd_pkg::KIND_TAKE_OLDEST: begin
                    n_slot = r_slot;
                end
                default: begin
                    n_slot = r_slot;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

[hw/rtl/move_to_front_unique_deque_top.sv]
// Top level of the move-to-front unique deque: cell row, control and result register.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries one operation per beat: tuser holds the kind
// (push newest, push oldest, pop newest, pop oldest) and tdata the identifier.
// The master stream returns one result beat per operation, in order: tdata
// holds the popped identifier, the newest and oldest entries and the count;
// tuser holds the popped-valid and overflow flags.
// Throughput is one operation per cycle while the receiver keeps taking
// results: every cell compares its slot with the incoming identifier at
// once and the row shifts on the accepting edge, so the match chain through
// the row of cells sets the cycle time. A result passes through the pending
// flags, then the result register: the row updates on the accepting edge,
// and the result register loads from the row once the output register frees.
// Reset empties the store at once; slot contents are not cleared, only the
// count. When the receiver stalls, one result waits in the output register
// and one more is held pending; tready on the slave side then drops until
// the output register frees up.

module move_to_front_unique_deque_top #(
    parameter int CAPACITY = mtfd_pkg::CAPACITY_DEF,
    parameter int ID_WIDTH = mtfd_pkg::ID_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] entry_id
    input  logic [mtfd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [1:0] kind
    input  logic [mtfd_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] popped_id, [31:16] newest_id, [47:32] oldest_id, [52:48] count, [55:53] zero
    output logic [mtfd_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] popped_valid, [1] overflow
    output logic [mtfd_pkg::OUT_TUSER_W-1:0]    o_m_axis_tuser
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PAD_W = mtfd_pkg::OUT_TDATA_W - 3 * mtfd_pkg::ID_FIELD_W
                           - mtfd_pkg::CNT_FIELD_W;

    logic                  w_accept;
    logic [1:0]            w_kind;
    logic [ID_WIDTH-1:0]   w_id;
    logic                  w_is_push;
    logic                  w_hit;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_drop;
    logic                  w_out_free;
    logic [CNT_W-1:0]      w_target;
    logic [ID_WIDTH-1:0]   w_popped;
    logic                  w_popped_valid;
    logic [ID_WIDTH-1:0]   w_oldest;
    logic [ID_WIDTH-1:0]   w_newest;
    mtfd_pkg::t_cell_ctrl  w_ctrl;

    logic [CAPACITY-1:0]   w_match;
    logic [CAPACITY:0]     w_seen;
    logic [ID_WIDTH-1:0]   w_slot  [CAPACITY];
    logic [ID_WIDTH-1:0]   w_tail  [CAPACITY];
    logic [ID_WIDTH-1:0]   w_left  [CAPACITY];
    logic [ID_WIDTH-1:0]   w_right [CAPACITY];

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_pend;
    logic [ID_WIDTH-1:0]   r_pend_popped;
    logic                  r_pend_pv;
    logic                  r_pend_ovf;
    logic                  r_out_valid;
    logic [mtfd_pkg::OUT_TDATA_W-1:0] r_out_tdata;
    logic [mtfd_pkg::OUT_TUSER_W-1:0] r_out_tuser;

    // Input decode.
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_kind    = i_s_axis_tuser[1:0];
    assign w_id      = ID_WIDTH'(i_s_axis_tdata[mtfd_pkg::ID_FIELD_W-1:0]);
    assign w_is_push = (w_kind == mtfd_pkg::KIND_ADD_NEWEST)
                    || (w_kind == mtfd_pkg::KIND_ADD_OLDEST);

    // The match chain through the row ends in the hit flag.
    assign w_seen[0] = 1'b0;
    assign w_hit     = w_seen[CAPACITY];
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_drop    = w_is_push && !w_hit && w_full;
    assign w_target  = w_hit ? (r_count - CNT_W'(1)) : r_count;

    assign w_ctrl.en   = w_accept && (w_is_push ? !w_drop : !w_empty);
    assign w_ctrl.kind = w_kind;

    // Cells wired to neighbors; the new id feeds the left end, the right end folds back.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            assign w_left[gi] = w_id;
        end else begin : g_mid_l
            assign w_left[gi] = w_slot[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign w_right[gi] = w_slot[gi];
        end else begin : g_mid_r
            assign w_right[gi] = w_slot[gi+1];
        end

        mtfd_cell #(
            .ID_WIDTH (ID_WIDTH),
            .CNT_W    (CNT_W),
            .IDX      (gi)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_id     (w_id),
            .i_count  (r_count),
            .i_target (w_target),
            .i_left   (w_left[gi]),
            .i_right  (w_right[gi]),
            .i_seen   (w_seen[gi]),
            .o_seen   (w_seen[gi+1]),
            .o_match  (w_match[gi]),
            .o_slot   (w_slot[gi]),
            .o_tail   (w_tail[gi])
        );
    end

    // Oldest entry: only the last live cell drives a nonzero tail value.
    always_comb begin
        w_oldest = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_oldest = w_oldest | w_tail[i];
        end
    end

    assign w_newest = w_empty ? '0 : w_slot[0];

    // Popped identifier and the next count.
    always_comb begin
        w_popped       = '0;
        w_popped_valid = 1'b0;
        n_count        = r_count;
        unique case (w_kind) inside
            mtfd_pkg::KIND_ADD_NEWEST, mtfd_pkg::KIND_ADD_OLDEST: begin
                if (!w_hit && !w_full) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            mtfd_pkg::KIND_TAKE_NEWEST: begin
                if (!w_empty) begin
                    w_popped       = w_slot[0];
                    w_popped_valid = 1'b1;
                    n_count        = r_count - CNT_W'(1);
                end
            end
            mtfd_pkg::KIND_TAKE_OLDEST: begin
                if (!w_empty) begin
                    w_popped       = w_oldest;
                    w_popped_valid = 1'b1;
                    n_count        = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Handshake: a pending result moves out whenever the output register frees.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_pend || w_out_free;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_pend  <= 1'b1;
            end else if (w_out_free) begin
                r_pend  <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_pend;
            end
        end
    end

    // Pending flags and the result register; the row is read as it stands after the update.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_popped <= w_popped;
            r_pend_pv     <= w_popped_valid;
            r_pend_ovf    <= w_drop;
        end
        if (r_pend && w_out_free) begin
            r_out_tdata <= {PAD_W'(0),
                            mtfd_pkg::CNT_FIELD_W'(r_count),
                            mtfd_pkg::ID_FIELD_W'(w_oldest),
                            mtfd_pkg::ID_FIELD_W'(w_newest),
                            mtfd_pkg::ID_FIELD_W'(r_pend_popped)};
            r_out_tuser <= {r_pend_ovf, r_pend_pv};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count beyond capacity");

    // Identifiers stay unique, so at most one cell matches.
    a_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_is_push |-> $onehot0(w_match))
        else $error("more than one cell matched the identifier");

    // An overflow result only comes from a full store that it left unchanged.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && r_pend_ovf |-> r_count == CNT_W'(CAPACITY))
        else $error("overflow flagged without a full store");

    // A result never reports both a pop and a dropped push.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !(r_pend_pv && r_pend_ovf))
        else $error("popped and overflow both set");

    // A pending result reaches the output as soon as the output register frees.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && w_out_free |=> r_out_valid)
        else $error("pending result was lost");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the move-to-front unique deque top level.
`timescale 1ns / 1ps

module tb;

    localparam int STORE_DEPTH = mtfd_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ID_POOL_N   = 24;

    // One result beat as the deque should report it.
    typedef struct {
        logic [15:0] popped_id;
        logic        popped_valid;
        logic [15:0] newest_id;
        logic [15:0] oldest_id;
        logic [4:0]  count;
        logic        overflow;
    } t_deque_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    // [15:0] entry_id
    logic [mtfd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // [1:0] kind
    logic [mtfd_pkg::IN_TUSER_W-1:0]  i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b1;
    // [15:0] popped_id, [31:16] newest_id, [47:32] oldest_id, [52:48] count, [55:53] zero
    logic [mtfd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    // [0] popped_valid, [1] overflow
    logic [mtfd_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser;

    // Mirror of the store, newest entry first, and the results still owed.
    logic [15:0]   model_ids[$];
    t_deque_result owed_results[$];

    logic [15:0] id_pool[ID_POOL_N];
    bit          send_gaps = 1'b0;
    bit          recv_stalls = 1'b0;
    int          errors = 0;
    int          cycle_cnt = 0;
    int          recv_hold = 0;
    int          n_ops = 0;
    int          n_overflows = 0;
    int          n_moves = 0;
    int          n_empty_pops = 0;

    move_to_front_unique_deque_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Update the mirrored store for one accepted operation and queue its result.
    task automatic predict_step(input logic [1:0] kind, input logic [15:0] id);
        t_deque_result r;
        int            hit_at;
        int            take_at;
        hit_at = -1;
        take_at = 0;
        r.popped_id    = '0;
        r.popped_valid = 1'b0;
        r.overflow     = 1'b0;
        case (kind) inside
            mtfd_pkg::KIND_ADD_NEWEST, mtfd_pkg::KIND_ADD_OLDEST: begin
                foreach (model_ids[i]) begin
                    if (hit_at < 0 && model_ids[i] == id) begin
                        hit_at = i;
                    end
                end
                if (hit_at >= 0) begin
                    model_ids.delete(hit_at);
                    n_moves++;
                end
                if (model_ids.size() >= STORE_DEPTH) begin
                    r.overflow = 1'b1;
                    n_overflows++;
                end else if (kind == mtfd_pkg::KIND_ADD_NEWEST) begin
                    model_ids.insert(0, id);
                end else begin
                    model_ids.insert(model_ids.size(), id);
                end
            end
            mtfd_pkg::KIND_TAKE_NEWEST, mtfd_pkg::KIND_TAKE_OLDEST: begin
                if (model_ids.size() == 0) begin
                    n_empty_pops++;
                end else begin
                    take_at = (kind == mtfd_pkg::KIND_TAKE_NEWEST) ? 0
                                                                  : model_ids.size() - 1;
                    r.popped_valid = 1'b1;
                    r.popped_id    = model_ids[take_at];
                    model_ids.delete(take_at);
                end
            end
        endcase
        r.count     = 5'(model_ids.size());
        r.newest_id = (model_ids.size() > 0) ? model_ids[0] : '0;
        r.oldest_id = (model_ids.size() > 0) ? model_ids[model_ids.size() - 1] : '0;
        owed_results.insert(owed_results.size(), r);
        n_ops++;
    endtask

    // Send one operation beat after an optional random gap.
    task automatic send_op(input logic [1:0] kind, input logic [15:0] id);
        int gap;
        gap = send_gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= id;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_step(kind, id);
    endtask

    // Hold the sender off until every owed result has come back.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Compare every result beat with the oldest owed result, then pick the next stall.
    always @(posedge i_clk) begin
        t_deque_result r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result beat %0h / %0h", o_m_axis_tdata, o_m_axis_tuser);
                errors++;
            end else begin
                r = owed_results[0];
                owed_results.delete(0);
                check_field("popped_id", r.popped_id, o_m_axis_tdata[15:0]);
                check_field("newest_id", r.newest_id, o_m_axis_tdata[31:16]);
                check_field("oldest_id", r.oldest_id, o_m_axis_tdata[47:32]);
                check_field("count", 16'(r.count), 16'(o_m_axis_tdata[52:48]));
                check_field("tdata_pad", 16'd0, 16'(o_m_axis_tdata[55:53]));
                check_field("popped_valid", 16'(r.popped_valid), 16'(o_m_axis_tuser[0]));
                check_field("overflow", 16'(r.overflow), 16'(o_m_axis_tuser[1]));
            end
            recv_hold = recv_stalls ? $urandom_range(0, 11) : 0;
        end
        i_m_axis_tready <= (recv_hold == 0);
        if (recv_hold > 0) begin
            recv_hold--;
        end
    end

    // Pops on an empty store, pushes to both ends, moves of present entries.
    task automatic test_ends_and_empty();
        send_op(mtfd_pkg::KIND_TAKE_NEWEST, 16'h1234);
        send_op(mtfd_pkg::KIND_TAKE_OLDEST, 16'hFFFF);
        send_op(mtfd_pkg::KIND_ADD_NEWEST, 16'hFFFF);
        send_op(mtfd_pkg::KIND_ADD_OLDEST, 16'h0000);
        send_op(mtfd_pkg::KIND_ADD_NEWEST, 16'h0000);
        send_op(mtfd_pkg::KIND_ADD_OLDEST, 16'hFFFF);
        send_op(mtfd_pkg::KIND_ADD_NEWEST, 16'hFFFF);
        send_op(mtfd_pkg::KIND_TAKE_OLDEST, 16'h0000);
        send_op(mtfd_pkg::KIND_TAKE_NEWEST, 16'h0000);
        send_op(mtfd_pkg::KIND_TAKE_NEWEST, 16'hFFFF);
        drain_results();
    endtask

    // Fill to capacity, overflow on a new id, move present ids while full, pop both ends.
    task automatic test_full_store();
        for (int i = 0; i < STORE_DEPTH; i++) begin
            send_op((i % 2) ? mtfd_pkg::KIND_ADD_OLDEST : mtfd_pkg::KIND_ADD_NEWEST,
                    16'h5A00 + 16'(i));
        end
        send_op(mtfd_pkg::KIND_ADD_NEWEST, 16'hA5A5);
        send_op(mtfd_pkg::KIND_ADD_OLDEST, 16'h5A03);
        send_op(mtfd_pkg::KIND_ADD_NEWEST, 16'h5A0E);
        send_op(mtfd_pkg::KIND_TAKE_OLDEST, 16'h0000);
        send_op(mtfd_pkg::KIND_TAKE_NEWEST, 16'h0000);
        drain_results();
    endtask

    // Random phases: push-heavy, pop-heavy and balanced, mostly on a small id pool.
    task automatic test_random_churn();
        int          style;
        int          pick;
        logic [1:0]  kind;
        logic [15:0] id;
        foreach (id_pool[i]) begin
            id_pool[i] = 16'($urandom);
        end
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int ph = 0; ph < 17; ph++) begin
            style       = $urandom_range(0, 2);
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 50; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < ((style == 0) ? 80 : (style == 1) ? 30 : 55)) begin
                    kind = $urandom_range(0, 1) ? mtfd_pkg::KIND_ADD_OLDEST
                                                : mtfd_pkg::KIND_ADD_NEWEST;
                end else begin
                    kind = $urandom_range(0, 1) ? mtfd_pkg::KIND_TAKE_OLDEST
                                                : mtfd_pkg::KIND_TAKE_NEWEST;
                end
                id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL_N - 1)]
                                                   : 16'($urandom);
                send_op(kind, id);
            end
            if (ph % 4 == 3) begin
                drain_results();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ends_and_empty();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        test_full_store();
        test_random_churn();
        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d operations: %0d moves of present ids, %0d full-store drops,",
                 n_ops, n_moves, n_overflows);
        $display("and %0d pops on an empty store, with random gaps and stalls on both sides.",
                 n_empty_pops);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
